// File: hw/rtl/kplock_pkg.sv
// Shared definitions for the keypad PIN lock: event codes, key codes,
// register map and configuration reset values.
// No dependencies.
`default_nettype none

package kplock_pkg;

	// Default entry length
	localparam int unsigned PIN_DIGITS_DEF = 4;

	// Register map: byte address width and word index per register
	localparam int unsigned ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_PIN_CODE     = 2'd0,
		REG_MAX_FAILURES = 2'd1,
		REG_LOCKOUT_SECS = 2'd2
	} reg_idx_t;

	// Configuration reset values ("1234", three tries, thirty seconds)
	localparam logic [31:0] PIN_CODE_RST     = 32'h3132_3334;
	localparam logic [3:0]  MAX_FAILURES_RST = 4'd3;
	localparam logic [7:0]  LOCKOUT_SECS_RST = 8'd30;

	// Item kinds
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Special keys
	localparam logic [7:0] KEY_NONE  = 8'h00;
	localparam logic [7:0] KEY_CHECK = 8'h23; // '#'
	localparam logic [7:0] KEY_STAR  = 8'h2A; // '*'
	localparam logic [7:0] KEY_DEL   = 8'h44; // 'D'

	// Result event codes
	typedef enum logic [3:0] {
		EV_NONE         = 4'd0,
		EV_STORED       = 4'd1,
		EV_DELETED      = 4'd2,
		EV_CLEARED      = 4'd3,
		EV_ACCEPTED     = 4'd4,
		EV_REJECTED     = 4'd5,
		EV_LOCK_START   = 4'd6,
		EV_LOCK_TICK    = 4'd7,
		EV_LOCK_END     = 4'd8,
		EV_CLOSED       = 4'd9,
		EV_ALREADY_OPEN = 4'd10
	} ev_code_t;

	// PIN character idx, first character in the top byte; zero past the fourth
	function automatic logic [7:0] pin_char(input logic [31:0] pin, input int unsigned idx);
		logic [7:0] ch;
		ch = 8'h00;
		if (idx < 4) begin
			ch = 8'(pin >> (24 - 8 * idx));
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/keypad_pin_lock_with_lockout.sv
// Keypad PIN lock with failed-attempt lockout and light alarm (top level).
// An accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless out_stall holds; one compare/update pass.
// Reset: arst_n clears state and output valid, and loads the default PIN, limits.
// Entry characters have no reset; only written characters are ever compared.
// Depends on kplock_pkg.
`default_nettype none

module keypad_pin_lock_with_lockout #(
	parameter int unsigned PIN_DIGITS = kplock_pkg::PIN_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kplock_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          opcode,
	input  wire logic [7:0]                    key_code,
	input  wire logic                          light_detected,
	// Result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [3:0]                         event_res,
	output logic                               lock_open,
	output logic                               alarm_on,
	output logic [2:0]                         digits_entered,
	output logic [3:0]                         failed_count,
	output logic [7:0]                         lockout_left,
	output logic                               buzzer_pulse
);
	import kplock_pkg::*;

	localparam int unsigned CNT_W = $clog2(PIN_DIGITS + 1);
	localparam int unsigned IDX_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

	// Configuration registers
	logic [31:0] pin_code_q;
	logic [3:0]  max_failures_q;
	logic [7:0]  lockout_secs_q;
	logic        cfg_wr;

	// Lock state
	logic [7:0]       entry_q [PIN_DIGITS];
	logic [CNT_W-1:0] count_q;
	logic [3:0]       fail_q;
	logic             open_q;
	logic             alarm_q;
	logic [7:0]       lock_q;

	// Input register
	logic       valid_s1;
	logic       opcode_s1;
	logic [7:0] key_s1;
	logic       light_s1;

	// Result register
	logic       valid_s2;
	ev_code_t   ev_s2;
	logic       open_s2;
	logic       alarm_s2;
	logic [2:0] digits_s2;
	logic [3:0] fail_s2;
	logic [7:0] lock_s2;
	logic       buzz_s2;

	// Handshake
	logic advance;
	logic commit;
	logic in_xfer;

	// Next state and result
	logic [CNT_W-1:0] n_count;
	logic [3:0]       n_fail;
	logic [3:0]       fail_inc;
	logic             n_open;
	logic             n_alarm;
	logic [7:0]       n_lock;
	ev_code_t         ev;
	logic             buzz;
	logic             entry_wr;
	logic             match;
	logic [2:0]       n_digits;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_code_q     <= PIN_CODE_RST;
			max_failures_q <= MAX_FAILURES_RST;
			lockout_secs_q <= LOCKOUT_SECS_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_PIN_CODE:     pin_code_q     <= pwdata;
				REG_MAX_FAILURES: max_failures_q <= pwdata[3:0];
				REG_LOCKOUT_SECS: lockout_secs_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_PIN_CODE:     prdata = pin_code_q;
			REG_MAX_FAILURES: prdata = {28'd0, max_failures_q};
			REG_LOCKOUT_SECS: prdata = {24'd0, lockout_secs_q};
			default:          prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	// Result register moves when empty or taken; input register refills as it drains
	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign commit   = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			opcode_s1 <= opcode;
			key_s1    <= key_code;
			light_s1  <= light_detected;
		end
	end

	// ---------------- PIN compare ----------------
	always_comb begin
		match = (count_q == CNT_W'(PIN_DIGITS)) && (pin_char(pin_code_q, PIN_DIGITS) == 8'h00);
		for (int unsigned i = 0; i < PIN_DIGITS; i++) begin
			if (entry_q[i] != pin_char(pin_code_q, i)) begin
				match = 1'b0;
			end
		end
	end

	// ---------------- step logic ----------------
	assign fail_inc = fail_q + 4'd1;

	always_comb begin
		n_count  = count_q;
		n_fail   = fail_q;
		n_open   = open_q;
		n_alarm  = alarm_q;
		n_lock   = lock_q;
		ev       = EV_NONE;
		buzz     = 1'b0;
		entry_wr = 1'b0;
		if (lock_q != 8'd0) begin
			// Lockout: only ticks count down
			if (opcode_s1 == OP_TICK) begin
				n_lock = lock_q - 8'd1;
				buzz   = 1'b1;
				ev     = (lock_q == 8'd1) ? EV_LOCK_END : EV_LOCK_TICK;
			end
		end else begin
			// Light while closed latches the alarm, then the key is handled
			if (!open_q && light_s1) begin
				n_alarm = 1'b1;
			end
			if (opcode_s1 == OP_KEY && key_s1 != KEY_NONE) begin
				case (key_s1)
					KEY_CHECK: begin
						if (open_q) begin
							ev = EV_ALREADY_OPEN;
						end else if (match) begin
							n_fail  = 4'd0;
							n_alarm = 1'b0;
							n_open  = 1'b1;
							ev      = EV_ACCEPTED;
						end else if (fail_inc >= max_failures_q) begin
							n_fail = 4'd0;
							n_lock = lockout_secs_q;
							ev     = EV_LOCK_START;
						end else begin
							n_fail = fail_inc;
							ev     = EV_REJECTED;
						end
						n_count = '0;
					end
					KEY_STAR: begin
						if (open_q) begin
							n_open  = 1'b0;
							n_alarm = 1'b0;
							ev      = EV_CLOSED;
						end else begin
							n_count = '0;
							ev      = EV_CLEARED;
						end
					end
					KEY_DEL: begin
						if (count_q != '0) begin
							n_count = count_q - CNT_W'(1);
							ev      = EV_DELETED;
						end
					end
					default: begin
						if (count_q < CNT_W'(PIN_DIGITS) && !open_q) begin
							entry_wr = 1'b1;
							n_count  = count_q + CNT_W'(1);
							ev       = EV_STORED;
						end
					end
				endcase
			end
		end
	end

	// Display count saturates at seven
	assign n_digits = (32'(n_count) > 32'd7) ? 3'd7 : 3'(n_count);

	// ---------------- state registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fail_q  <= 4'd0;
			open_q  <= 1'b0;
			alarm_q <= 1'b0;
			lock_q  <= 8'd0;
		end else if (commit) begin
			count_q <= n_count;
			fail_q  <= n_fail;
			open_q  <= n_open;
			alarm_q <= n_alarm;
			lock_q  <= n_lock;
		end
	end

	// Entry characters
	always_ff @(posedge clk) begin
		if (commit && entry_wr) begin
			entry_q[count_q[IDX_W-1:0]] <= key_s1;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ev_s2     <= ev;
			open_s2   <= n_open;
			alarm_s2  <= n_alarm && (n_lock == 8'd0);
			digits_s2 <= n_digits;
			fail_s2   <= n_fail;
			lock_s2   <= n_lock;
			buzz_s2   <= buzz;
		end
	end

	assign out_valid      = valid_s2;
	assign event_res      = ev_s2;
	assign lock_open      = open_s2;
	assign alarm_on       = alarm_s2;
	assign digits_entered = digits_s2;
	assign failed_count   = fail_s2;
	assign lockout_left   = lock_s2;
	assign buzzer_pulse   = buzz_s2;

	// ---------------- assertions ----------------
	// Buzzer only on lockout ticks
	a_buzz_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && buzzer_pulse) |-> (event_res == EV_LOCK_TICK || event_res == EV_LOCK_END))
		else $error("buzzer pulse without lockout tick event");

	// Alarm output is muted during a lockout
	a_alarm_mute: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lockout_left != 8'd0) |-> !alarm_on)
		else $error("alarm sounding during lockout");

	// An open safe has no pending failures and no lockout
	a_open_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lock_open) |-> (failed_count == 4'd0 && lockout_left == 8'd0))
		else $error("open safe with failures or lockout");

	// A held result keeps the input side stalled when the input register is full
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |-> in_stall)
		else $error("input accepted while pipeline is blocked");

endmodule

`default_nettype wire
